[rtl/core/bse_pkg.sv]
package bse_pkg;

  localparam int HRP_MAX = 32;
  localparam int HRP_AW  = $clog2(HRP_MAX);
  localparam int HRP_LW  = $clog2(HRP_MAX + 1);

  localparam logic [1:0] KIND_HRP_CHAR = 2'd0;
  localparam logic [1:0] KIND_HRP_END  = 2'd1;
  localparam logic [1:0] KIND_DATA     = 2'd2;
  localparam logic [1:0] KIND_FINISH   = 2'd3;

  localparam logic [29:0] GEN0     = 30'h3b6a57b2;
  localparam logic [29:0] GEN1     = 30'h26508e6d;
  localparam logic [29:0] GEN2     = 30'h1ea119fa;
  localparam logic [29:0] GEN3     = 30'h3d4233dd;
  localparam logic [29:0] GEN4     = 30'h2a1462b3;
  localparam logic [29:0] CHK_INIT = 30'd1;

  localparam logic [7:0]   CHAR_SEP     = 8'h31;
  localparam logic [255:0] B32_ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } item_t;

  // One step of the BCH polymod over GF(32).
  function automatic logic [29:0] feed(input logic [29:0] c, input logic [4:0] x);
    logic [4:0]  top;
    logic [29:0] r;
    top = c[29:25];
    r   = {c[24:0], x};
    if (top[0]) r = r ^ GEN0;
    if (top[1]) r = r ^ GEN1;
    if (top[2]) r = r ^ GEN2;
    if (top[3]) r = r ^ GEN3;
    if (top[4]) r = r ^ GEN4;
    return r;
  endfunction

  function automatic logic [7:0] b32_char(input logic [4:0] g);
    logic [4:0] pos;
    pos = 5'd31 - g;
    return B32_ALPHABET[{pos, 3'b000} +: 8];
  endfunction

endpackage

[rtl/core/bse_ram.sv]
module bse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/bse_front.sv]
module bse_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        kind,
  input  logic [7:0]        value,
  output logic              q_valid,
  output bse_pkg::item_t    q_item,
  input  logic              q_pop
);

  // Two-entry queue between the input channel and the sequencer.
  bse_pkg::item_t ent [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= '{kind: kind, value: value};
    end
  end

endmodule

[rtl/core/bse_back.sv]
module bse_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  bse_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_char,
  output logic           last,
  output logic           error
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HRP  = 3'd1;
  localparam logic [2:0] ST_ONE  = 3'd2;
  localparam logic [2:0] ST_DATA = 3'd3;
  localparam logic [2:0] ST_PAD  = 3'd4;
  localparam logic [2:0] ST_ZERO = 3'd5;
  localparam logic [2:0] ST_CHK  = 3'd6;

  logic [2:0]                  state, state_next;
  logic [bse_pkg::HRP_LW-1:0]  hrp_length, hrp_length_next;
  logic [29:0]                 chk, chk_next;
  logic [3:0]                  left_bits, left_bits_next;
  logic [2:0]                  left_cnt, left_cnt_next;
  logic [11:0]                 acc, acc_next;
  logic [3:0]                  acc_bits, acc_bits_next;
  logic [bse_pkg::HRP_LW-1:0]  idx, idx_next;
  logic [2:0]                  step, step_next;

  logic                        out_free;
  logic                        emit;
  logic [7:0]                  emit_char;
  logic                        emit_last;
  logic                        emit_err;

  logic                        we;
  logic [bse_pkg::HRP_AW-1:0]  raddr;
  logic [4:0]                  rdata;

  logic [3:0]                  nb;
  logic [11:0]                 acc_sh;
  logic [4:0]                  grp;
  logic [4:0]                  mask5;
  logic [8:0]                  pad_sh;

  bse_ram #(.WIDTH(5), .DEPTH(bse_pkg::HRP_MAX)) u_hrp_ram (
    .clk   (clk),
    .we    (we),
    .waddr (hrp_length[bse_pkg::HRP_AW-1:0]),
    .wdata (q_item.value[4:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free = !out_valid || !out_stall;
  assign nb       = acc_bits - 4'd5;
  assign acc_sh   = acc >> nb;
  assign grp      = acc_sh[4:0];
  assign mask5    = (5'd1 << nb) - 5'd1;
  assign pad_sh   = {5'b00000, left_bits} << (3'd5 - left_cnt);

  always_comb begin
    state_next      = state;
    hrp_length_next = hrp_length;
    chk_next        = chk;
    left_bits_next  = left_bits;
    left_cnt_next   = left_cnt;
    acc_next        = acc;
    acc_bits_next   = acc_bits;
    idx_next        = idx;
    step_next       = step;
    q_pop           = 1'b0;
    we              = 1'b0;
    emit            = 1'b0;
    emit_char       = q_item.value;
    emit_last       = 1'b0;
    emit_err        = 1'b0;
    // The store is read one entry ahead of the one consumed this cycle.
    raddr           = idx[bse_pkg::HRP_AW-1:0] + bse_pkg::HRP_AW'(1);

    case (state)
      ST_IDLE: begin
        raddr = '0;
        if (q_valid) begin
          case (q_item.kind)
            bse_pkg::KIND_HRP_CHAR: begin
              if (out_free) begin
                q_pop = 1'b1;
                emit  = 1'b1;
                if (hrp_length < bse_pkg::HRP_LW'(bse_pkg::HRP_MAX)) begin
                  we              = 1'b1;
                  hrp_length_next = hrp_length + bse_pkg::HRP_LW'(1);
                  chk_next        = bse_pkg::feed(chk, {2'b00, q_item.value[7:5]});
                end else begin
                  emit_err = 1'b1;
                end
              end
            end
            bse_pkg::KIND_HRP_END: begin
              q_pop      = 1'b1;
              chk_next   = bse_pkg::feed(chk, 5'd0);
              idx_next   = '0;
              state_next = ST_HRP;
            end
            bse_pkg::KIND_DATA: begin
              q_pop         = 1'b1;
              acc_next      = {left_bits, q_item.value};
              acc_bits_next = {1'b0, left_cnt} + 4'd8;
              state_next    = ST_DATA;
            end
            bse_pkg::KIND_FINISH: begin
              q_pop      = 1'b1;
              step_next  = '0;
              state_next = (left_cnt != 3'd0) ? ST_PAD : ST_ZERO;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_HRP: begin
        if (idx == hrp_length) begin
          state_next = ST_ONE;
        end else begin
          chk_next = bse_pkg::feed(chk, rdata);
          idx_next = idx + bse_pkg::HRP_LW'(1);
        end
      end
      ST_ONE: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_char  = bse_pkg::CHAR_SEP;
          state_next = ST_IDLE;
        end
      end
      ST_DATA: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_char     = bse_pkg::b32_char(grp);
          chk_next      = bse_pkg::feed(chk, grp);
          acc_bits_next = nb;
          if (nb < 4'd5) begin
            left_cnt_next  = nb[2:0];
            left_bits_next = acc[3:0] & mask5[3:0];
            state_next     = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_char  = bse_pkg::b32_char(pad_sh[4:0]);
          chk_next   = bse_pkg::feed(chk, pad_sh[4:0]);
          step_next  = '0;
          state_next = ST_ZERO;
        end
      end
      ST_ZERO: begin
        step_next = step + 3'd1;
        if (step == 3'd5) begin
          chk_next   = bse_pkg::feed(chk, 5'd0) ^ bse_pkg::CHK_INIT;
          step_next  = '0;
          state_next = ST_CHK;
        end else begin
          chk_next = bse_pkg::feed(chk, 5'd0);
        end
      end
      ST_CHK: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = bse_pkg::b32_char(chk[29:25]);
          chk_next  = {chk[24:0], 5'd0};
          step_next = step + 3'd1;
          if (step == 3'd5) begin
            emit_last       = 1'b1;
            hrp_length_next = '0;
            chk_next        = bse_pkg::CHK_INIT;
            left_bits_next  = '0;
            left_cnt_next   = '0;
            step_next       = '0;
            state_next      = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hrp_length <= '0;
      chk        <= bse_pkg::CHK_INIT;
      left_bits  <= '0;
      left_cnt   <= '0;
      idx        <= '0;
      step       <= '0;
      acc_bits   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      hrp_length <= hrp_length_next;
      chk        <= chk_next;
      left_bits  <= left_bits_next;
      left_cnt   <= left_cnt_next;
      idx        <= idx_next;
      step       <= step_next;
      acc_bits   <= acc_bits_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (emit) begin
      out_char <= emit_char;
      last     <= emit_last;
      error    <= emit_err;
    end
  end

endmodule

[rtl/core/bech32_string_encoder.sv]
// A beat is registered into the input queue, from which the sequencer takes it; each character
// the sequencer emits leaves through the output register, which holds it while out_stall is high.
// Throughput is set by the sequencer, which takes one beat at a time and does at most one polymod
// step per cycle, waiting while the output is stalled.
// Reset (rst, synchronous): clears the queue, out_valid and the encoder state except the
// accumulator; the hrp store, the accumulator and out_char, last and error are not cleared.
module bech32_string_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last,
  output logic       error
);

  logic           q_valid;
  logic           q_pop;
  bse_pkg::item_t q_item;

  bse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .value    (value),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  bse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last),
    .error     (error)
  );

endmodule

[rtl/core/bse_checker.sv]
module bse_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       last,
  input logic       error
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last) && $stable(error))
    else $error("stalled output beat changed");

  a_last_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> !error)
    else $error("checksum beat flagged as error");

  // Six checksum characters always precede the end of a string.
  a_no_back_to_back_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !(out_valid && last))
    else $error("two final beats in a row");

endmodule

bind bech32_string_encoder bse_checker u_bse_checker (.*);

[tb/sv/tb_bech32_string_encoder.sv]
module tb_bech32_string_encoder;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } enc_char_t;

  // Tracks the encoder state and holds the characters the block still owes us.
  class bech32_char_tracker;
    logic [4:0]  hrp_low [bse_pkg::HRP_MAX];
    int unsigned hrp_len = 0;
    logic [29:0] poly = 30'd1;
    logic [3:0]  spare_bits = 4'd0;
    int unsigned spare_cnt = 0;
    string       charset = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
    enc_char_t   due_chars[$];
    int          mismatches = 0;
    int          chars_checked = 0;
    int          strings_done = 0;
    int          overflows = 0;

    function void clear_state();
      hrp_len = 0;
      poly = 30'd1;
      spare_bits = 4'd0;
      spare_cnt = 0;
    endfunction

    function logic [29:0] gen_word(int i);
      case (i)
        0: return 30'h3b6a57b2;
        1: return 30'h26508e6d;
        2: return 30'h1ea119fa;
        3: return 30'h3d4233dd;
        default: return 30'h2a1462b3;
      endcase
    endfunction

    function void polymod_step(logic [4:0] x);
      logic [4:0] top;
      int i;
      top = poly[29:25];
      poly = {poly[24:0], x};
      for (i = 0; i < 5; i++)
        if (top[i]) poly = poly ^ gen_word(i);
    endfunction

    function logic [7:0] alphabet_char(logic [4:0] g);
      return charset[g];
    endfunction

    function void push_char(logic [7:0] ch, logic last, logic err);
      enc_char_t c;
      c.ch = ch;
      c.last = last;
      c.err = err;
      due_chars.insert(due_chars.size(), c);
    endfunction

    function void accept_item(logic [1:0] k, logic [7:0] v);
      logic [11:0] acc;
      int unsigned nbits;
      logic [4:0]  g;
      logic [29:0] chk_word;
      int          i;
      case (k)
        bse_pkg::KIND_HRP_CHAR: begin
          if (hrp_len < bse_pkg::HRP_MAX) begin
            hrp_low[hrp_len] = v[4:0];
            hrp_len++;
            polymod_step({2'b00, v[7:5]});
            push_char(v, 1'b0, 1'b0);
          end else begin
            overflows++;
            push_char(v, 1'b0, 1'b1);
          end
        end
        bse_pkg::KIND_HRP_END: begin
          polymod_step(5'd0);
          for (i = 0; i < hrp_len; i++)
            polymod_step(hrp_low[i]);
          push_char(bse_pkg::CHAR_SEP, 1'b0, 1'b0);
        end
        bse_pkg::KIND_DATA: begin
          acc = {spare_bits, v};
          nbits = spare_cnt + 8;
          while (nbits >= 5) begin
            nbits = nbits - 5;
            g = acc[nbits +: 5];
            polymod_step(g);
            push_char(alphabet_char(g), 1'b0, 1'b0);
          end
          spare_cnt = nbits;
          spare_bits = acc[3:0] & ((4'd1 << nbits) - 4'd1);
        end
        bse_pkg::KIND_FINISH: begin
          // Leftover bits are padded with zeros on the right into one last group.
          if (spare_cnt != 0) begin
            g = {1'b0, spare_bits} << (5 - spare_cnt);
            polymod_step(g);
            push_char(alphabet_char(g), 1'b0, 1'b0);
          end
          for (i = 0; i < 6; i++)
            polymod_step(5'd0);
          chk_word = poly ^ 30'd1;
          for (i = 0; i < 6; i++) begin
            g = chk_word[25 - 5 * i +: 5];
            push_char(alphabet_char(g), i == 5, 1'b0);
          end
          strings_done++;
          clear_state();
        end
        default: begin
        end
      endcase
    endfunction

    function void check_char(logic [7:0] ch, logic last, logic err);
      enc_char_t want;
      chars_checked++;
      if (due_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat: expected none, actual char %h last %b error %b",
                 $time, ch, last, err);
      end else begin
        want = due_chars.pop_front();
        if (ch !== want.ch) begin
          mismatches++;
          $display("%0t: out_char expected %h actual %h", $time, want.ch, ch);
        end
        if (last !== want.last) begin
          mismatches++;
          $display("%0t: last expected %b actual %b", $time, want.last, last);
        end
        if (err !== want.err) begin
          mismatches++;
          $display("%0t: error expected %b actual %b", $time, want.err, err);
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] kind = bse_pkg::KIND_HRP_CHAR;
  logic [7:0] value = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       last;
  logic       error;

  int send_idle_pct = 31;
  int recv_stall_pct = 60;
  int items_sent = 0;

  bech32_char_tracker tracker;

  bech32_string_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last),
    .error     (error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_char(out_char, last, error);
  end

  task automatic send_item(input logic [1:0] k, input logic [7:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.accept_item(k, v);
    items_sent++;
  endtask

  function automatic logic [7:0] hrp_char_value();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    else return 8'($urandom_range(33, 126));
  endfunction

  task automatic send_string(input int hrp_n, input int data_n, input bit with_end,
                             input bit with_finish);
    int i;
    for (i = 0; i < hrp_n; i++) send_item(bse_pkg::KIND_HRP_CHAR, hrp_char_value());
    if (with_end) send_item(bse_pkg::KIND_HRP_END, 8'($urandom_range(0, 255)));
    for (i = 0; i < data_n; i++) send_item(bse_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
    if (with_finish) send_item(bse_pkg::KIND_FINISH, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int phase;
    int pick;
    int hrp_n;
    int data_n;
    tracker = new;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: an empty string, field extremes, a repeated hrp end, hrp characters
    // after the separator, finish with and without leftover bits, data without hrp end.
    send_item(bse_pkg::KIND_FINISH, 8'h00);
    send_item(bse_pkg::KIND_HRP_CHAR, 8'h00);
    send_item(bse_pkg::KIND_HRP_CHAR, 8'hff);
    send_item(bse_pkg::KIND_HRP_END, 8'hff);
    send_item(bse_pkg::KIND_HRP_END, 8'h00);
    send_item(bse_pkg::KIND_HRP_CHAR, 8'h61);
    send_item(bse_pkg::KIND_DATA, 8'h00);
    send_item(bse_pkg::KIND_DATA, 8'hff);
    send_item(bse_pkg::KIND_DATA, 8'ha5);
    send_item(bse_pkg::KIND_DATA, 8'h5a);
    send_item(bse_pkg::KIND_DATA, 8'h3c);
    send_item(bse_pkg::KIND_FINISH, 8'hff);
    send_item(bse_pkg::KIND_HRP_CHAR, 8'h62);
    send_item(bse_pkg::KIND_HRP_END, 8'h00);
    send_item(bse_pkg::KIND_DATA, 8'hff);
    send_item(bse_pkg::KIND_FINISH, 8'h00);
    send_item(bse_pkg::KIND_DATA, 8'h01);
    send_item(bse_pkg::KIND_FINISH, 8'h00);

    // An hrp longer than the store, so the overflow path is always hit.
    send_string(34, 3, 1'b1, 1'b1);

    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 60;
        recv_stall_pct = 31;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      while (items_sent < 66 + 50 * phase) begin
        pick = $urandom_range(0, 99);
        hrp_n = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
        data_n = $urandom_range(0, 12);
        if (pick < 70) begin
          send_string(hrp_n, data_n, 1'b1, 1'b1);
        end else if (pick < 85) begin
          send_string(hrp_n, data_n, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          repeat ($urandom_range(1, 4))
            send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end
    end

    in_valid <= 1'b0;
    while (tracker.due_chars.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d beats, finished %0d strings, checked %0d characters.",
             items_sent, tracker.strings_done, tracker.chars_checked);
    $display("Hrp store overflowed on %0d characters; %0d mismatches seen.",
             tracker.overflows, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.due_chars.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timed out with %0d characters outstanding.", tracker.due_chars.size());
    $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bse_pkg.sv
rtl/core/bse_ram.sv
rtl/core/bse_front.sv
rtl/core/bse_back.sv
rtl/core/bech32_string_encoder.sv
rtl/core/bse_checker.sv
tb/sv/tb_bech32_string_encoder.sv
